[sv/dfq_pkg.sv]
// ----------------------------------------------------------------------------
// dfq_pkg
// shared types and constants of the deduplicating fifo queue
// ----------------------------------------------------------------------------
`default_nettype none

package dfq_pkg;

    localparam int DATA_W  = 32;
    localparam int VALUE_W = 31;

    localparam logic [DATA_W-1:0] FAIL_VALUE = '1;

    // request kind codes
    typedef enum logic
    {
        KIND_APPEND = 1'b0,
        KIND_POP    = 1'b1
    } kind_t;

    // result status codes
    typedef enum logic [2:0]
    {
        ST_OK        = 3'd0,
        ST_NEGATIVE  = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

endpackage

`default_nettype wire

[sv/dfq_if.sv]
// ----------------------------------------------------------------------------
// dfq_req_if / dfq_rsp_if
// valid/ready channels for requests and results of the queue
// ----------------------------------------------------------------------------
`default_nettype none

interface dfq_req_if
    import dfq_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface dfq_rsp_if
    import dfq_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    status_t                  status;
    logic signed [DATA_W-1:0] result_value;

    modport source (output valid, output status, output result_value, input ready);
    modport sink   (input valid, input status, input result_value, output ready);
endinterface

`default_nettype wire

[sv/dfq_ram.sv]
// ----------------------------------------------------------------------------
// dfq_ram
// single-port synchronous ram, registered read, no reset
// ----------------------------------------------------------------------------
`default_nettype none

module dfq_ram
#(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16
)
(
    input  wire logic                                  clk,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic                                  we,
    input  wire logic [WIDTH-1:0]                      wdata,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[sv/dedup_fifo_queue_unit.sv]
// ----------------------------------------------------------------------------
// dedup_fifo_queue_unit
// fifo queue of non-negative 31-bit values that refuses duplicates
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH values in a ring inside one single-port ram.
// Each request gives exactly one result. An append (kind 0) is refused with
// status 1 when the value is negative, status 2 when the value is already
// queued, status 3 when the queue is full (checked in that order); otherwise
// the value is written at the tail and echoed back with status 0. A pop
// (kind 1) returns and removes the oldest value, or status 4 when empty.
// Failed requests return all ones as result_value. One request is worked on
// at a time: the duplicate check reads the queued entries one per cycle
// through the single ram port, so an append to a non-empty queue scans up to
// every queued entry before it ends; pops and refused negative appends skip
// the scan. The result sits in an output register, so the next request is
// taken while a result still waits on the rsp side.
// The ram needs no clearing pass after reset: only queued entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module dedup_fifo_queue_unit
    import dfq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    dfq_req_if.sink   req,
    dfq_rsp_if.source rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_POP_WAIT,
        S_DONE
    } state_t;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] ptr);
        logic [AW-1:0] nxt;
        if (ptr == AW'(DEPTH - 1))
        begin
            nxt = '0;
        end
        else
        begin
            nxt = ptr + AW'(1);
        end
        return nxt;
    endfunction

    // sequencer state
    state_t              state_reg,     state_next;
    logic [VALUE_W-1:0]  value_reg,     value_next;
    logic [AW-1:0]       rd_ptr_reg,    rd_ptr_next;
    logic [AW-1:0]       wr_ptr_reg,    wr_ptr_next;
    logic [CW-1:0]       count_reg,     count_next;
    logic [AW-1:0]       scan_addr_reg, scan_addr_next;
    logic [CW-1:0]       scan_left_reg, scan_left_next;
    status_t             res_status_reg, res_status_next;
    logic [DATA_W-1:0]   res_value_reg, res_value_next;

    // output register
    logic                rsp_valid_reg,  rsp_valid_next;
    status_t             rsp_status_reg, rsp_status_next;
    logic [DATA_W-1:0]   rsp_value_reg,  rsp_value_next;

    // ram port
    logic [AW-1:0]       mem_addr;
    logic                mem_we;
    logic [VALUE_W-1:0]  mem_wdata;
    logic [VALUE_W-1:0]  mem_rdata;

    logic                req_fire;
    logic                out_free;

    assign req.ready        = (state_reg == S_IDLE);
    assign req_fire         = req.valid && req.ready;
    assign out_free         = !rsp_valid_reg || rsp.ready;

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.result_value = rsp_value_reg;

    dfq_ram
    #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    )
    u_store
    (
        .clk   (clk),
        .addr  (mem_addr),
        .we    (mem_we),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        value_next      = value_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        count_next      = count_reg;
        scan_addr_next  = scan_addr_reg;
        scan_left_next  = scan_left_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_value_next  = rsp_value_reg;
        mem_addr        = rd_ptr_reg;
        mem_we          = 1'b0;
        mem_wdata       = value_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    value_next = req.value[VALUE_W-1:0];
                    state_next = S_DONE;
                    if (req.kind == KIND_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            res_value_next  = FAIL_VALUE;
                        end
                        else
                        begin
                            // head entry read issued now
                            mem_addr   = rd_ptr_reg;
                            state_next = S_POP_WAIT;
                        end
                    end
                    else if (req.value[DATA_W-1])
                    begin
                        res_status_next = ST_NEGATIVE;
                        res_value_next  = FAIL_VALUE;
                    end
                    else if (count_reg == '0)
                    begin
                        // empty queue: nothing to scan, store the request value at once
                        mem_addr        = wr_ptr_reg;
                        mem_we          = 1'b1;
                        mem_wdata       = req.value[VALUE_W-1:0];
                        value_next      = req.value[VALUE_W-1:0];
                        wr_ptr_next     = ring_next(wr_ptr_reg);
                        count_next      = count_reg + CW'(1);
                        res_status_next = ST_OK;
                        res_value_next  = {1'b0, req.value[VALUE_W-1:0]};
                    end
                    else
                    begin
                        mem_addr       = rd_ptr_reg;
                        scan_addr_next = ring_next(rd_ptr_reg);
                        scan_left_next = count_reg;
                        state_next     = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // mem_rdata holds the entry read in the previous cycle
                if (mem_rdata == value_reg)
                begin
                    res_status_next = ST_DUPLICATE;
                    res_value_next  = FAIL_VALUE;
                    state_next      = S_DONE;
                end
                else if (scan_left_reg == CW'(1))
                begin
                    state_next = S_DONE;
                    if (count_reg == CW'(DEPTH))
                    begin
                        res_status_next = ST_FULL;
                        res_value_next  = FAIL_VALUE;
                    end
                    else
                    begin
                        mem_addr        = wr_ptr_reg;
                        mem_we          = 1'b1;
                        wr_ptr_next     = ring_next(wr_ptr_reg);
                        count_next      = count_reg + CW'(1);
                        res_status_next = ST_OK;
                        res_value_next  = {1'b0, value_reg};
                    end
                end
                else
                begin
                    mem_addr       = scan_addr_reg;
                    scan_addr_next = ring_next(scan_addr_reg);
                    scan_left_next = scan_left_reg - CW'(1);
                end
            end

            S_POP_WAIT:
            begin
                rd_ptr_next     = ring_next(rd_ptr_reg);
                count_next      = count_reg - CW'(1);
                res_status_next = ST_OK;
                res_value_next  = {1'b0, mem_rdata};
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_value_next  = res_value_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        scan_addr_reg  <= scan_addr_next;
        scan_left_reg  <= scan_left_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        rsp_status_reg <= rsp_status_next;
        rsp_value_reg  <= rsp_value_next;
    end

    // occupancy never goes past the ring size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
    else $error("entry count above depth");

    // one request in flight: no new request the cycle after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req.ready)
    else $error("request taken while busy");

    // occupancy moves by at most one per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg)
               || count_reg == $past(count_reg) + CW'(1)
               || count_reg == $past(count_reg) - CW'(1)))
    else $error("entry count jumped");

    // failed results carry all ones, ok results are non-negative
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> rsp.result_value == FAIL_VALUE)
    else $error("failed result without all-ones value");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_OK) |-> !rsp.result_value[DATA_W-1])
    else $error("ok result is negative");

endmodule

`default_nettype wire
